### src/sorted_table_interval_hunt_macros.svh
// Assertion macros shared by the sorted table interval hunt RTL.
`ifndef SORTED_TABLE_INTERVAL_HUNT_MACROS_SVH
`define SORTED_TABLE_INTERVAL_HUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define STH_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sth: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define STH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sth: next-cycle check failed");

`endif

### src/sth_pkg.sv
// Package: codes, control word type and microcode program of the interval hunt.
`default_nettype none

package sth_pkg;

   localparam int IDX_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam int PC_W       = 4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TABLE_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_STRICT_BOUNDS = 1'b1;

   // Step addresses of the program.
   localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
   localparam logic [PC_W-1:0] PC_MIN  = 4'd1;
   localparam logic [PC_W-1:0] PC_MAX  = 4'd2;
   localparam logic [PC_W-1:0] PC_H0   = 4'd3;
   localparam logic [PC_W-1:0] PC_UP   = 4'd4;
   localparam logic [PC_W-1:0] PC_L0   = 4'd5;
   localparam logic [PC_W-1:0] PC_DN   = 4'd6;
   localparam logic [PC_W-1:0] PC_BIS  = 4'd7;
   localparam logic [PC_W-1:0] PC_FIN  = 4'd8;

   typedef enum logic [2:0] {
      AC_START   = 3'd0,
      AC_CHK_MIN = 3'd1,
      AC_CHK_MAX = 3'd2,
      AC_UP      = 3'd3,
      AC_DOWN    = 3'd4,
      AC_BIS     = 3'd5,
      AC_FIN     = 3'd6
   } act_type;

   typedef enum logic [2:0] {
      CO_QUERY     = 3'd0,
      CO_LT        = 3'd1,
      CO_GE        = 3'd2,
      CO_RESOLVED  = 3'd3,
      CO_MID_EQ_LO = 3'd4,
      CO_RSP_FREE  = 3'd5
   } cond_type;

   typedef enum logic [2:0] {
      AS_ZERO   = 3'd0,
      AS_NM1    = 3'd1,
      AS_LO_IN  = 3'd2,
      AS_HI_IN  = 3'd3,
      AS_MID_IN = 3'd4
   } addr_sel_type;

   // One control word: the action, the branch condition, and for each outcome
   // of the condition the table read address and the next step.
   typedef struct packed {
      act_type             act;
      cond_type            cond;
      addr_sel_type        addr_t;
      addr_sel_type        addr_f;
      logic [PC_W-1:0]     next_t;
      logic [PC_W-1:0]     next_f;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         PC_IDLE: w = '{AC_START,   CO_QUERY,     AS_ZERO,   AS_ZERO,  PC_MIN,  PC_IDLE};
         PC_MIN:  w = '{AC_CHK_MIN, CO_LT,        AS_ZERO,   AS_NM1,   PC_FIN,  PC_MAX};
         PC_MAX:  w = '{AC_CHK_MAX, CO_RESOLVED,  AS_ZERO,   AS_HI_IN, PC_FIN,  PC_H0};
         PC_H0:   w = '{AC_UP,      CO_GE,        AS_HI_IN,  AS_LO_IN, PC_UP,   PC_L0};
         PC_UP:   w = '{AC_UP,      CO_LT,        AS_MID_IN, AS_HI_IN, PC_BIS,  PC_UP};
         PC_L0:   w = '{AC_DOWN,    CO_GE,        AS_ZERO,   AS_LO_IN, PC_FIN,  PC_DN};
         PC_DN:   w = '{AC_DOWN,    CO_GE,        AS_MID_IN, AS_LO_IN, PC_BIS,  PC_DN};
         PC_BIS:  w = '{AC_BIS,     CO_MID_EQ_LO, AS_ZERO,   AS_MID_IN, PC_FIN, PC_BIS};
         PC_FIN:  w = '{AC_FIN,     CO_RSP_FREE,  AS_ZERO,   AS_ZERO,  PC_IDLE, PC_FIN};
         default: w = '{AC_START,   CO_QUERY,     AS_ZERO,   AS_ZERO,  PC_MIN,  PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### src/sth_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/sorted_table_interval_hunt.sv
// Top level: sorted table interval hunt with a microcoded search sequencer.
//
// Usage. The req_ channel carries transactions of two kinds. A write
// (req_cmd low) stores req_table_value at req_entry_index and gives no
// response. A query (req_cmd high) locates req_query_value in the table and
// gives one rsp_ transaction: the lower index of the interval that holds it,
// clamped to the table, and an out-of-range flag when strict bounds are on.
// The csr_ channel sets table_size (index 0) and strict_bounds (index 1);
// write it only while no query is in flight. csr_ready is always high.
// A query occupies the sequencer (req_ready low) through its hunt reads and
// its bisection reads, made one at a time through the single read port.
// The hunt starts from the interval found by the last query that fell
// inside the table.
// Reset clears the sequencer, the remembered interval (to 0), and sets
// table_size to 1 and strict_bounds to 0. Table contents are undefined
// until written. If the receiver stalls, the response waits in the output
// register and the sequencer holds its last step until the slot frees.
`default_nettype none
`include "sorted_table_interval_hunt_macros.svh"

module sorted_table_interval_hunt #(
   parameter int TABLE_DEPTH = 1024,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [sth_pkg::IDX_W-1:0]      req_entry_index,
   input  wire logic signed [VALUE_WIDTH-1:0]  req_table_value,
   input  wire logic signed [VALUE_WIDTH-1:0]  req_query_value,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [sth_pkg::IDX_W-1:0]           rsp_interval_index,
   output logic                                rsp_out_of_range,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sth_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sth_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int STEP_W = CNT_W + 1;
   localparam int SUM_W  = STEP_W + 1;

   // Registers.
   logic [sth_pkg::PC_W-1:0]   pc_ff, pc_in;
   logic signed [VALUE_WIDTH-1:0] v_ff, v_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [ADDR_W-1:0]          lo_ff, lo_in;
   logic [ADDR_W-1:0]          hi_ff, hi_in;
   logic [ADDR_W-1:0]          mid_ff, mid_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ADDR_W-1:0]          res_ff, res_in;
   logic                       outside_ff, outside_in;
   logic                       upd_ff, upd_in;
   logic [ADDR_W-1:0]          last_ff, last_in;
   logic [sth_pkg::SIZE_W-1:0] table_size_ff, table_size_in;
   logic                       strict_ff, strict_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sth_pkg::IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                       rsp_oor_ff, rsp_oor_in;

   // Datapath signals.
   sth_pkg::ucode_type         uw;
   sth_pkg::addr_sel_type      asel;
   logic                       take;
   logic                       req_fire;
   logic                       query_fire;
   logic                       wr_fire;
   logic                       wr_in_range;
   logic [CNT_W-1:0]           n_eff;
   logic [CNT_W-1:0]           nm1;
   logic [ADDR_W-1:0]          nm1_a;
   logic [ADDR_W-1:0]          nm2_a;
   logic                       n_is_one;
   logic                       lt;
   logic                       gt;
   logic [CNT_W-1:0]           last_inc;
   logic [SUM_W-1:0]           up_sum;
   logic [ADDR_W:0]            mid_sum;
   logic [ADDR_W-1:0]          rd_addr;
   logic [ADDR_W-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0]     rd_data;

   assign req_ready   = (pc_ff == sth_pkg::PC_IDLE);
   assign csr_ready   = 1'b1;
   assign req_fire    = req_valid && req_ready;
   assign query_fire  = req_fire && (req_cmd == sth_pkg::CMD_QUERY);
   assign wr_in_range = (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign wr_fire     = req_fire && (req_cmd == sth_pkg::CMD_WRITE) && wr_in_range;
   assign wr_addr     = ADDR_W'(req_entry_index);

   // A size of zero acts as one; a size beyond the depth acts as the depth.
   always_comb begin
      if (table_size_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(table_size_ff) > 32'(TABLE_DEPTH)) begin
         n_eff = CNT_W'(TABLE_DEPTH);
      end else begin
         n_eff = CNT_W'(table_size_ff);
      end
   end

   assign nm1      = n_ff - CNT_W'(1);
   assign nm1_a    = ADDR_W'(nm1);
   assign nm2_a    = ADDR_W'(n_ff - CNT_W'(2));
   assign n_is_one = (n_ff == CNT_W'(1));
   assign lt       = (v_ff < $signed(rd_data));
   assign gt       = (v_ff > $signed(rd_data));
   assign last_inc = CNT_W'(last_ff) + CNT_W'(1);
   assign up_sum   = SUM_W'(hi_ff) + SUM_W'(step_ff);

   assign uw = sth_pkg::ucode_rom(pc_ff);

   always_comb begin
      case (uw.cond)
         sth_pkg::CO_QUERY:     take = query_fire;
         sth_pkg::CO_LT:        take = lt;
         sth_pkg::CO_GE:        take = !lt;
         sth_pkg::CO_RESOLVED:  take = !lt || n_is_one;
         sth_pkg::CO_MID_EQ_LO: take = (mid_ff == lo_ff);
         sth_pkg::CO_RSP_FREE:  take = !rsp_valid_ff || rsp_ready;
         default:               take = 1'b0;
      endcase
   end

   always_comb begin
      v_in         = v_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      outside_in   = outside_ff;
      upd_in       = upd_ff;
      last_in      = last_ff;
      rsp_index_in = rsp_index_ff;
      rsp_oor_in   = rsp_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (uw.act)
         sth_pkg::AC_START: begin
            if (query_fire) begin
               v_in       = req_query_value;
               n_in       = n_eff;
               outside_in = 1'b0;
               upd_in     = 1'b0;
            end
         end
         sth_pkg::AC_CHK_MIN: begin
            if (lt) begin
               res_in     = '0;
               outside_in = 1'b1;
            end
         end
         sth_pkg::AC_CHK_MAX: begin
            if (gt) begin
               res_in     = nm1_a;
               outside_in = 1'b1;
            end else if (n_is_one) begin
               res_in = '0;
               upd_in = 1'b1;
            end else if (!lt) begin
               // Equal to the last entry: report the last full interval.
               res_in = nm2_a;
               upd_in = 1'b1;
            end else begin
               if (last_inc >= nm1) begin
                  lo_in = nm2_a;
                  hi_in = nm1_a;
               end else begin
                  lo_in = last_ff;
                  hi_in = ADDR_W'(last_inc);
               end
               step_in = STEP_W'(1);
            end
         end
         sth_pkg::AC_UP: begin
            // Past the last entry the bound clamps to it; the next read then
            // always falls below it and bisection takes over.
            if (!lt) begin
               lo_in = hi_ff;
               if (up_sum >= SUM_W'(nm1)) begin
                  hi_in = nm1_a;
               end else begin
                  hi_in = ADDR_W'(up_sum);
               end
               step_in = step_ff << 1;
            end
         end
         sth_pkg::AC_DOWN: begin
            // The first entry never exceeds the value here, so a downward
            // step that reaches index zero always ends the hunt.
            if (lt) begin
               hi_in = lo_ff;
               if (STEP_W'(lo_ff) > step_ff) begin
                  lo_in = ADDR_W'(STEP_W'(lo_ff) - step_ff);
               end else begin
                  lo_in = '0;
               end
               step_in = step_ff << 1;
            end else begin
               res_in = lo_ff;
               upd_in = 1'b1;
            end
         end
         sth_pkg::AC_BIS: begin
            if (mid_ff == lo_ff) begin
               res_in = lo_ff;
               upd_in = 1'b1;
            end else if (lt) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff;
            end
         end
         sth_pkg::AC_FIN: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = sth_pkg::IDX_W'(res_ff);
               rsp_oor_in   = outside_ff && strict_ff;
               if (upd_ff) begin
                  last_in = res_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
   assign mid_in  = mid_sum[ADDR_W:1];
   assign asel    = take ? uw.addr_t : uw.addr_f;
   assign pc_in   = take ? uw.next_t : uw.next_f;

   always_comb begin
      unique case (asel)
         sth_pkg::AS_ZERO:   rd_addr = '0;
         sth_pkg::AS_NM1:    rd_addr = nm1_a;
         sth_pkg::AS_LO_IN:  rd_addr = lo_in;
         sth_pkg::AS_HI_IN:  rd_addr = hi_in;
         sth_pkg::AS_MID_IN: rd_addr = mid_in;
         default:            rd_addr = '0;
      endcase
   end

   always_comb begin
      table_size_in = table_size_ff;
      strict_in     = strict_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sth_pkg::REG_TABLE_SIZE:    table_size_in = csr_data;
            sth_pkg::REG_STRICT_BOUNDS: strict_in     = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= sth_pkg::PC_IDLE;
         last_ff       <= '0;
         table_size_ff <= sth_pkg::SIZE_W'(1);
         strict_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         last_ff       <= last_in;
         table_size_ff <= table_size_in;
         strict_ff     <= strict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      step_ff      <= step_in;
      res_ff       <= res_in;
      outside_ff   <= outside_in;
      upd_ff       <= upd_in;
      rsp_index_ff <= rsp_index_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   sth_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_fire),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_index = rsp_index_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

   `STH_ASSERT_NEXT(a_query_starts_search, clock, reset, query_fire, pc_ff == sth_pkg::PC_MIN)
   `STH_ASSERT_IMPL(a_bisect_bounds_ordered, clock, reset, pc_ff == sth_pkg::PC_BIS, lo_ff < hi_ff)
   `STH_ASSERT_IMPL(a_result_in_table, clock, reset, pc_ff == sth_pkg::PC_FIN, CNT_W'(res_ff) < n_ff)
   `STH_ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(pc_ff) == sth_pkg::PC_FIN)

endmodule

`default_nettype wire
